@@ rtl/core/circle_octant_point_generator_defines.svh @@
// ----------------------------------------------------------------------------
// Circle octant point generator assertion macros
// Concurrent check wrappers shared by the RTL of the point generator.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OCTANT_POINT_GENERATOR_DEFINES_SVH
`define CIRCLE_OCTANT_POINT_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define COG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define COG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define COG_ASSERT(lbl, prop, msg)
`define COG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/cog_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle octant point generator package
// Widths, operation codes and the step record passed from front to back.
// ----------------------------------------------------------------------------
package cog_pkg;

  localparam int COORD_BITS  = 11;
  localparam int RADIUS_BITS = 10;
  localparam int OFF_BITS    = RADIUS_BITS + 2;
  localparam int DEC_BITS    = RADIUS_BITS + 6;
  localparam int OUT_BITS    = COORD_BITS + 2;
  localparam int IDX_BITS    = 3;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_BITS  = 1;
  localparam int Q_CNT_BITS  = 2;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [IDX_BITS-1:0] LAST_IDX = 3'd7;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [OFF_BITS-1:0]   x;
    logic [OFF_BITS-1:0]   y;
    logic                  done;
  } job_t;

endpackage

@@ rtl/core/circle_octant_point_generator.sv @@
// ----------------------------------------------------------------------------
// Circle octant point generator
// Midpoint circle generator: a start transfer loads centre and radius, each
// advance transfer runs one step; every step yields eight mirrored points.
//
// channel  dir  tdata                                   tuser         tlast
// in_      in   center_x, center_y, circle_radius       operation     -
// out_     out  point_x, point_y                        circle_done   last_of_step
//
// An accepted start or advance emits eight points, one per cycle while out_tready
// holds, from the emitter's registered output stage.
// A two-entry step queue lets the front take two items ahead of the emitter.
// Advance while idle is dropped and emits nothing.
// Reset is synchronous and clears the circle state, the queue and the output.
// ----------------------------------------------------------------------------
module circle_octant_point_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // center_x[10:0], center_y[21:11], circle_radius[31:22]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // point_x[12:0], point_y[25:13], zero[31:26]
  output logic        out_tuser,  // circle_done
  output logic        out_tlast
);

  localparam int CX_LO = 0;
  localparam int CY_LO = cog_pkg::COORD_BITS;
  localparam int R_LO  = 2 * cog_pkg::COORD_BITS;
  localparam int PAD   = 32 - 2 * cog_pkg::OUT_BITS;

  logic                                full, push, pop, q_not_empty, accept;
  cog_pkg::job_t                       push_job, pop_job;
  logic signed [cog_pkg::OUT_BITS-1:0] point_x, point_y;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  cog_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .op            (in_tuser),
    .center_x      (in_tdata[CX_LO +: cog_pkg::COORD_BITS]),
    .center_y      (in_tdata[CY_LO +: cog_pkg::COORD_BITS]),
    .circle_radius (in_tdata[R_LO +: cog_pkg::RADIUS_BITS]),
    .push          (push),
    .push_job      (push_job)
  );

  cog_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (q_not_empty),
    .full      (full)
  );

  cog_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .q_job        (pop_job),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_step (out_tlast),
    .circle_done  (out_tuser)
  );

  assign out_tdata = {{PAD{1'b0}}, point_y, point_x};

endmodule

@@ rtl/core/cog_front.sv @@
// ----------------------------------------------------------------------------
// Circle octant point generator front end
// Accepts items, keeps the circle state, runs one midpoint step per advance
// while a circle is active and pushes the resulting offsets into the step queue.
// ----------------------------------------------------------------------------
`include "circle_octant_point_generator_defines.svh"

module cog_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            op,
  input  logic [cog_pkg::COORD_BITS-1:0]  center_x,
  input  logic [cog_pkg::COORD_BITS-1:0]  center_y,
  input  logic [cog_pkg::RADIUS_BITS-1:0] circle_radius,
  output logic                            push,
  output cog_pkg::job_t                   push_job
);

  logic [cog_pkg::COORD_BITS-1:0] cx_r, cx_nxt;
  logic [cog_pkg::COORD_BITS-1:0] cy_r, cy_nxt;
  logic [cog_pkg::OFF_BITS-1:0]   x_r, x_nxt;
  logic [cog_pkg::OFF_BITS-1:0]   y_r, y_nxt;
  logic [cog_pkg::DEC_BITS-1:0]   d_r, d_nxt;
  logic                           active_r, active_nxt;
  logic                           done;
  logic [cog_pkg::DEC_BITS-1:0]   xs, ys, r_ext;

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    d_nxt      = d_r;
    active_nxt = active_r;
    done       = 1'b0;
    push       = 1'b0;
    xs         = '0;
    ys         = '0;
    r_ext      = cog_pkg::DEC_BITS'(circle_radius);
    if (accept && op == cog_pkg::OP_START) begin
      cx_nxt     = center_x;
      cy_nxt     = center_y;
      x_nxt      = '0;
      y_nxt      = cog_pkg::OFF_BITS'(circle_radius);
      d_nxt      = cog_pkg::DEC_BITS'(3) - (r_ext << 1);
      active_nxt = 1'b1;
      push       = 1'b1;
    end else if (accept && active_r) begin
      x_nxt = x_r + 1'b1;
      if (!d_r[cog_pkg::DEC_BITS-1]) begin
        y_nxt = y_r - 1'b1;
        xs    = cog_pkg::DEC_BITS'(signed'(x_nxt));
        ys    = cog_pkg::DEC_BITS'(signed'(y_nxt));
        d_nxt = d_r + ((xs - ys) << 2) + cog_pkg::DEC_BITS'(10);
      end else begin
        xs    = cog_pkg::DEC_BITS'(signed'(x_nxt));
        d_nxt = d_r + (xs << 2) + cog_pkg::DEC_BITS'(6);
      end
      done = signed'(y_nxt) < signed'(x_nxt);
      if (done) begin
        active_nxt = 1'b0;
      end
      push = 1'b1;
    end
  end

  assign push_job = '{cx: cx_nxt, cy: cy_nxt, x: x_nxt, y: y_nxt, done: done};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      x_r      <= '0;
      y_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      d_r      <= d_nxt;
      active_r <= active_nxt;
    end
  end

  `COG_ASSERT(a_done_clears_active, (push && push_job.done) |=> !active_r,
              "finished circle left generator active")
  `COG_ASSERT(a_idle_advance_dropped, (accept && op == cog_pkg::OP_ADVANCE && !active_r) |-> !push,
              "advance while idle produced a step")

endmodule

@@ rtl/core/cog_queue.sv @@
// ----------------------------------------------------------------------------
// Circle octant point generator step queue
// Two-entry queue of step records between front end and point emitter.
// ----------------------------------------------------------------------------
`include "circle_octant_point_generator_defines.svh"

module cog_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cog_pkg::job_t push_job,
  input  logic          pop,
  output cog_pkg::job_t pop_job,
  output logic          not_empty,
  output logic          full
);

  cog_pkg::job_t                   slot_r [cog_pkg::Q_DEPTH];
  logic [cog_pkg::Q_PTR_BITS-1:0]  wp_r, wp_nxt;
  logic [cog_pkg::Q_PTR_BITS-1:0]  rp_r, rp_nxt;
  logic [cog_pkg::Q_CNT_BITS-1:0]  cnt_r, cnt_nxt;

  assign not_empty = cnt_r != '0;
  assign full      = cnt_r == cog_pkg::Q_CNT_BITS'(cog_pkg::Q_DEPTH);
  assign pop_job   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + cog_pkg::Q_CNT_BITS'(push) - cog_pkg::Q_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `COG_ASSERT(a_no_push_full, push |-> !full, "push into full step queue")
  `COG_ASSERT(a_no_pop_empty, pop |-> not_empty, "pop from empty step queue")

endmodule

@@ rtl/core/cog_back.sv @@
// ----------------------------------------------------------------------------
// Circle octant point generator point emitter
// Takes step records from the queue and emits the eight mirrored points,
// one per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`include "circle_octant_point_generator_defines.svh"

module cog_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_not_empty,
  input  cog_pkg::job_t                       q_job,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cog_pkg::OUT_BITS-1:0] point_x,
  output logic signed [cog_pkg::OUT_BITS-1:0] point_y,
  output logic                                last_of_step,
  output logic                                circle_done
);

  cog_pkg::job_t                       job_r, job_nxt;
  logic                                busy_r, busy_nxt;
  logic [cog_pkg::IDX_BITS-1:0]        idx_r, idx_nxt;
  logic                                ov_r, ov_nxt;
  logic signed [cog_pkg::OUT_BITS-1:0] px_r, px_nxt;
  logic signed [cog_pkg::OUT_BITS-1:0] py_r, py_nxt;
  logic                                last_r, last_nxt;
  logic                                done_r, done_nxt;
  logic                                adv, at_end;
  logic signed [cog_pkg::OUT_BITS-1:0] cx, cy, ox, oy;

  assign adv    = busy_r && (!ov_r || out_ready);
  assign at_end = idx_r == cog_pkg::LAST_IDX;
  assign pop    = q_not_empty && (!busy_r || (adv && at_end));

  assign cx = cog_pkg::OUT_BITS'(job_r.cx);
  assign cy = cog_pkg::OUT_BITS'(job_r.cy);
  assign ox = cog_pkg::OUT_BITS'(signed'(job_r.x));
  assign oy = cog_pkg::OUT_BITS'(signed'(job_r.y));

  always_comb begin
    case (idx_r)
      3'd0:    begin px_nxt = cx + ox; py_nxt = cy + oy; end
      3'd1:    begin px_nxt = cx - ox; py_nxt = cy + oy; end
      3'd2:    begin px_nxt = cx + ox; py_nxt = cy - oy; end
      3'd3:    begin px_nxt = cx - ox; py_nxt = cy - oy; end
      3'd4:    begin px_nxt = cx + oy; py_nxt = cy + ox; end
      3'd5:    begin px_nxt = cx - oy; py_nxt = cy + ox; end
      3'd6:    begin px_nxt = cx + oy; py_nxt = cy - ox; end
      default: begin px_nxt = cx - oy; py_nxt = cy - ox; end
    endcase
    last_nxt = at_end;
    done_nxt = job_r.done;
    job_nxt  = pop ? q_job : job_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (adv) begin
      busy_nxt = !at_end;
      idx_nxt  = idx_r + 1'b1;
    end else begin
      busy_nxt = busy_r;
      idx_nxt  = idx_r;
    end
    ov_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (adv) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      last_r <= last_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid    = ov_r;
  assign point_x      = px_r;
  assign point_y      = py_r;
  assign last_of_step = last_r;
  assign circle_done  = done_r;

  `COG_ASSERT(a_idx_needs_busy, (idx_r != '0) |-> busy_r, "point index moved while idle")
  `COG_ASSERT(a_end_drains, (adv && at_end && !q_not_empty) |=> !busy_r,
              "emitter stayed busy past the eighth point")

endmodule

@@ tb/circle_point_checker.sv @@
// ----------------------------------------------------------------------------
// Circle point checker
// Watches both streams of the circle point generator, runs its own midpoint
// circle stepper on every accepted input transfer and compares each accepted
// output transfer, field by field, against the oldest predicted point.
// ----------------------------------------------------------------------------
module circle_point_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // center_x[10:0], center_y[21:11], circle_radius[31:22]
  input  logic        in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // point_x[12:0], point_y[25:13], zero[31:26]
  input  logic        out_tuser,  // circle_done
  input  logic        out_tlast,  // last_of_step
  output int          mismatches,
  output int          points_pending
);

  typedef struct packed {
    logic [cog_pkg::OUT_BITS-1:0] px;
    logic [cog_pkg::OUT_BITS-1:0] py;
    logic                         last;
    logic                         done;
  } point_t;

  point_t expected_points[$];

  logic [cog_pkg::COORD_BITS-1:0]      centre_x = '0;
  logic [cog_pkg::COORD_BITS-1:0]      centre_y = '0;
  logic signed [cog_pkg::OFF_BITS-1:0] off_x    = '0;
  logic signed [cog_pkg::OFF_BITS-1:0] off_y    = '0;
  logic signed [cog_pkg::DEC_BITS-1:0] decision = '0;
  logic                                drawing  = 1'b0;

  initial begin
    mismatches     = 0;
    points_pending = 0;
  end

  task automatic push_point(input int px, input int py, input int k, input logic done);
    point_t p;
    p.px   = px[cog_pkg::OUT_BITS-1:0];
    p.py   = py[cog_pkg::OUT_BITS-1:0];
    p.last = (k == int'(cog_pkg::LAST_IDX));
    p.done = done;
    expected_points.push_back(p);
  endtask

  task automatic queue_mirrored_points(input logic done);
    int cx, cy, ox, oy;
    cx = centre_x;
    cy = centre_y;
    ox = off_x;
    oy = off_y;
    push_point(cx + ox, cy + oy, 0, done);
    push_point(cx - ox, cy + oy, 1, done);
    push_point(cx + ox, cy - oy, 2, done);
    push_point(cx - ox, cy - oy, 3, done);
    push_point(cx + oy, cy + ox, 4, done);
    push_point(cx - oy, cy + ox, 5, done);
    push_point(cx + oy, cy - ox, 6, done);
    push_point(cx - oy, cy - ox, 7, done);
  endtask

  task automatic advance_circle(input logic op, input logic [31:0] data);
    logic [cog_pkg::RADIUS_BITS-1:0] radius;
    int xi, yi, di;
    logic done;
    if (op == cog_pkg::OP_START) begin
      radius   = data[31:22];
      centre_x = data[10:0];
      centre_y = data[21:11];
      off_x    = '0;
      off_y    = {2'b00, radius};
      di       = 3 - 2 * int'(radius);
      decision = di[cog_pkg::DEC_BITS-1:0];
      drawing  = 1'b1;
      queue_mirrored_points(1'b0);
    end else if (drawing) begin
      off_x = off_x + 1;
      xi    = off_x;
      if (decision >= 0) begin
        off_y = off_y - 1;
        yi    = off_y;
        di    = decision + 4 * (xi - yi) + 10;
      end else begin
        di = decision + 4 * xi + 6;
      end
      decision = di[cog_pkg::DEC_BITS-1:0];
      done     = (off_y < off_x);
      if (done) begin
        drawing = 1'b0;
      end
      queue_mirrored_points(done);
    end
  endtask

  task automatic check_point();
    point_t want, got;
    got.px   = out_tdata[cog_pkg::OUT_BITS-1:0];
    got.py   = out_tdata[2*cog_pkg::OUT_BITS-1:cog_pkg::OUT_BITS];
    got.last = out_tlast;
    got.done = out_tuser;
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected point transfer: x %0d y %0d last %0b done %0b",
                 $signed(got.px), $signed(got.py), got.last, got.done);
      end
    end else begin
      want = expected_points.pop_front();
      if (want.px !== got.px || want.py !== got.py ||
          want.last !== got.last || want.done !== got.done) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display({"point mismatch: expected x %0d y %0d last %0b done %0b,",
                    " got x %0d y %0d last %0b done %0b"},
                   $signed(want.px), $signed(want.py), want.last, want.done,
                   $signed(got.px), $signed(got.py), got.last, got.done);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      centre_x = '0;
      centre_y = '0;
      off_x    = '0;
      off_y    = '0;
      decision = '0;
      drawing  = 1'b0;
      expected_points.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_point();
      end
      if (in_tvalid && in_tready) begin
        advance_circle(in_tuser, in_tdata);
      end
    end
    points_pending = expected_points.size();
  end

endmodule

@@ tb/circle_octant_point_generator_test.sv @@
// ----------------------------------------------------------------------------
// Circle octant point generator test
// Drives start and advance transfers with random gaps, random output stalls,
// one long output hold and drain pauses; the checker beside the block
// predicts every point and the top reports the verdict.
// ----------------------------------------------------------------------------
module circle_octant_point_generator_test;

  localparam int RANDOM_ITEMS = 270;
  localparam int LONG_HOLD    = 200;
  localparam int TAIL_CYCLES  = 24;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // center_x[10:0], center_y[21:11], circle_radius[31:22]
  logic        in_tuser   = 1'b0; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // point_x[12:0], point_y[25:13], zero[31:26]
  logic        out_tuser;         // circle_done
  logic        out_tlast;         // last_of_step

  logic in_fire_q  = 1'b0;
  logic out_fire_q = 1'b0;
  logic hold_request = 1'b0;
  logic no_idle      = 1'b0;
  int   items_sent   = 0;
  int   checker_errors;
  int   points_pending;

  circle_octant_point_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  circle_point_checker point_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatches     (checker_errors),
    .points_pending (points_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_fire_q  <= in_tvalid && in_tready;
    out_fire_q <= out_tvalid && out_tready;
  end

  initial begin
    #5_000_000;
    $display("circle_octant_point_generator_test: errors");
    $finish;
  end

  task automatic send_item(input logic op, input int cx, input int cy, input int radius);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {radius[cog_pkg::RADIUS_BITS-1:0], cy[cog_pkg::COORD_BITS-1:0],
                  cx[cog_pkg::COORD_BITS-1:0]};
    do @(negedge clk); while (!in_fire_q);
    items_sent++;
  endtask

  task automatic send_advance();
    send_item(cog_pkg::OP_ADVANCE, $urandom_range(0, 2047), $urandom_range(0, 2047),
              $urandom_range(0, 1023));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (points_pending != 0) @(negedge clk);
  endtask

  // output side: random stall per point, plus one long hold on request
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_fire_q);
    end
  end

  initial begin
    int pick, steps, target;
    int radius;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero radius, then advance while idle
    send_item(cog_pkg::OP_START, 0, 0, 0);
    send_advance();
    send_item(cog_pkg::OP_ADVANCE, 2047, 2047, 1023);
    send_item(cog_pkg::OP_ADVANCE, 0, 0, 0);
    // extreme centre and radius, abandoned by a new start
    send_item(cog_pkg::OP_START, 2047, 2047, 1023);
    send_advance();
    send_advance();
    send_item(cog_pkg::OP_START, 0, 0, 1023);
    send_advance();
    send_item(cog_pkg::OP_START, 2047, 0, 1);
    repeat (3) send_advance();
    send_item(cog_pkg::OP_START, 0, 2047, 3);
    repeat (5) send_advance();
    send_item(cog_pkg::OP_START, 1024, 1023, 512);
    send_item(cog_pkg::OP_ADVANCE, 2047, 2047, 1023);
    send_item(cog_pkg::OP_ADVANCE, 0, 0, 0);
    send_item(cog_pkg::OP_START, 1365, 682, 341);
    send_advance();

    // fill the block while the output is held off
    hold_request = 1'b1;
    no_idle      = 1'b1;
    send_item(cog_pkg::OP_START, $urandom_range(0, 2047), $urandom_range(0, 2047), 30);
    repeat (12) send_advance();
    no_idle = 1'b0;
    wait_drained();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      no_idle = ($urandom_range(0, 7) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 7) begin
        radius = $urandom_range(0, 40);
        send_item(cog_pkg::OP_START, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  radius);
        steps = radius * 3 / 4 + 1 + $urandom_range(0, 2);
        repeat (steps) send_advance();
      end else if (pick < 9) begin
        send_item(cog_pkg::OP_START, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 1023));
        repeat ($urandom_range(0, 5)) send_advance();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_item(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                    $urandom_range(0, 2047), $urandom_range(0, 1023));
        end
      end
      if ($urandom_range(0, 15) == 0) begin
        wait_drained();
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (checker_errors == 0 && points_pending == 0) begin
      $display("circle_octant_point_generator_test: clean");
    end else begin
      $display("circle_octant_point_generator_test: errors");
    end
    $finish;
  end

endmodule
